// File: rtl/core/assert_macros.svh
// Assertion macros shared by the PWM timer setting calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define PTSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptsc assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define PTSC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptsc assertion failed");

`endif

// File: rtl/core/ptsc_pkg.sv
// Types and constants of the PWM timer setting calculator.
package ptsc_pkg;

	localparam int LOG2_RANGE    = 16;
	localparam int COUNTER_RANGE = 1 << LOG2_RANGE;
	localparam int PRESC_MAX     = 65536;
	localparam int CNT_W         = 17;
	localparam int DIV_NUM_W     = 49;
	localparam int DIV_DEN_W     = 48;
	localparam int DIV_STEPS     = 33;

	localparam logic [1:0] REG_TIMER_CLOCK = 2'd0;
	localparam logic [1:0] REG_MIN_FREQ    = 2'd1;
	localparam logic [1:0] REG_MAX_FREQ    = 2'd2;
	localparam logic [1:0] REG_MAX_DUTY    = 2'd3;

	localparam logic RESULT_OK      = 1'b0;
	localparam logic RESULT_INVALID = 1'b1;

	// Per-transaction context that travels beside the divider data
	typedef struct packed {
		logic             ok;
		logic             en;
		logic [31:0]      freq;
		logic [15:0]      duty;
		logic [CNT_W-1:0] presc;
		logic [CNT_W-1:0] period;
		logic [CNT_W-1:0] pulse;
	} ptsc_side_t;

endpackage

// File: rtl/core/ptsc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ptsc_div
	import ptsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	input  ptsc_side_t           side_in,
	output logic                 out_vld,
	output logic [DIV_STEPS-1:0] quo,
	output ptsc_side_t           side_out
);

	logic [DIV_DEN_W-1:0] rem_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] low_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s  [DIV_STEPS];
	logic [DIV_DEN_W-1:0] den_s  [DIV_STEPS];
	ptsc_side_t           side_s [DIV_STEPS];
	logic                 vld_s  [DIV_STEPS];

	genvar g;
	generate
		for (g = 0; g < DIV_STEPS; g++) begin : g_step
			logic [DIV_DEN_W-1:0] r_prev;
			logic [DIV_STEPS-1:0] low_prev;
			logic [DIV_STEPS-1:0] q_prev;
			logic [DIV_DEN_W-1:0] d_prev;
			ptsc_side_t           sd_prev;
			logic                 v_prev;
			logic [DIV_DEN_W:0]   trial;
			logic                 ge;

			if (g == 0) begin : g_first
				assign r_prev   = DIV_DEN_W'(num >> DIV_STEPS);
				assign low_prev = num[DIV_STEPS-1:0];
				assign q_prev   = '0;
				assign d_prev   = den;
				assign sd_prev  = side_in;
				assign v_prev   = in_vld;
			end else begin : g_next
				assign r_prev   = rem_s[g-1];
				assign low_prev = low_s[g-1];
				assign q_prev   = quo_s[g-1];
				assign d_prev   = den_s[g-1];
				assign sd_prev  = side_s[g-1];
				assign v_prev   = vld_s[g-1];
			end

			// Shift in the next dividend bit and try the subtract
			assign trial = {r_prev, low_prev[DIV_STEPS-1]};
			assign ge    = trial >= {1'b0, d_prev};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (adv) begin
					vld_s[g] <= v_prev;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[g]  <= ge ? DIV_DEN_W'(trial - {1'b0, d_prev})
						: DIV_DEN_W'(trial);
					low_s[g]  <= low_prev << 1;
					quo_s[g]  <= {q_prev[DIV_STEPS-2:0], ge};
					den_s[g]  <= d_prev;
					side_s[g] <= sd_prev;
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[DIV_STEPS-1];
	assign quo      = quo_s[DIV_STEPS-1];
	assign side_out = side_s[DIV_STEPS-1];

endmodule

// File: rtl/core/pwm_timer_setting_calculator_top.sv
// Top level of the PWM timer setting calculator.
// A request passes stage 1, four 33-stage dividers with stages 2 to 7 between them, and the output register.
// Throughput: one request per cycle; the whole pipeline holds while the output stalls.
// Reset: arst_n clears all valid bits and loads the register reset values.
// Configuration writes are taken in any cycle (cfg_ready is always high).
`include "assert_macros.svh"
module pwm_timer_setting_calculator_top
	import ptsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        enable_request,
	input  logic [31:0] req_freq,
	input  logic [15:0] req_duty,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_code,
	output logic [15:0] prescaler_load,
	output logic [15:0] reload_load,
	output logic [16:0] compare_load,
	output logic [31:0] achieved_freq,
	output logic        output_enabled
);

	logic [31:0] clk_hz_q, min_f_q, max_f_q;
	logic [15:0] max_duty_q;
	logic        adv;

	// Write configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q   <= 32'd64000000;
			min_f_q    <= 32'd1;
			max_f_q    <= 32'd100000;
			max_duty_q <= 16'd1000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMER_CLOCK: clk_hz_q   <= cfg_data;
				REG_MIN_FREQ:    min_f_q    <= cfg_data;
				REG_MAX_FREQ:    max_f_q    <= cfg_data;
				REG_MAX_DUTY:    max_duty_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Advance the pipeline unless a result waits on a stalled output
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Stage 1: capture the transaction and check its arguments
	logic       vld_s1;
	ptsc_side_t side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.ok     <= (req_freq != 32'd0) && (req_freq >= min_f_q)
				&& (req_freq <= max_f_q) && (req_duty <= max_duty_q);
			side_s1.en     <= enable_request;
			side_s1.freq   <= req_freq;
			side_s1.duty   <= req_duty;
			side_s1.presc  <= '0;
			side_s1.period <= '0;
			side_s1.pulse  <= '0;
		end
	end

	// Divider 1: prescaler = ceil(clock / (f * range))
	logic [DIV_DEN_W-1:0] d1_den;
	logic [DIV_NUM_W-1:0] d1_num;
	logic                 d1_vld;
	logic [DIV_STEPS-1:0] d1_quo;
	ptsc_side_t           d1_side;
	assign d1_den = DIV_DEN_W'(side_s1.freq) << LOG2_RANGE;
	assign d1_num = DIV_NUM_W'(clk_hz_q) + DIV_NUM_W'(d1_den) - DIV_NUM_W'(1);

	ptsc_div u_div_presc (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(vld_s1), .num(d1_num), .den(d1_den), .side_in(side_s1),
		.out_vld(d1_vld), .quo(d1_quo), .side_out(d1_side)
	);

	// Stage 2: clamp the prescaler to 1..max
	logic       vld_s2;
	ptsc_side_t side_s2;
	ptsc_side_t d1_fix;
	always_comb begin
		d1_fix = d1_side;
		if (d1_quo == '0) begin
			d1_fix.presc = CNT_W'(1);
		end else if (d1_quo > DIV_STEPS'(PRESC_MAX)) begin
			d1_fix.presc = CNT_W'(PRESC_MAX);
		end else begin
			d1_fix.presc = CNT_W'(d1_quo);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= d1_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= d1_fix;
		end
	end

	// Stage 3: form prescaler * f
	logic                 vld_s3;
	ptsc_side_t           side_s3;
	logic [DIV_DEN_W-1:0] pf_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_s2;
			pf_s3   <= DIV_DEN_W'(DIV_NUM_W'(side_s2.presc) * DIV_NUM_W'(side_s2.freq));
		end
	end

	// Divider 2: period = round(clock / (prescaler * f))
	logic [DIV_NUM_W-1:0] d2_num;
	logic                 d2_vld;
	logic [DIV_STEPS-1:0] d2_quo;
	ptsc_side_t           d2_side;
	assign d2_num = DIV_NUM_W'(clk_hz_q) + DIV_NUM_W'(pf_s3 >> 1);

	ptsc_div u_div_period (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(vld_s3), .num(d2_num), .den(pf_s3), .side_in(side_s3),
		.out_vld(d2_vld), .quo(d2_quo), .side_out(d2_side)
	);

	// Stage 4: clamp the period to 2..range
	logic       vld_s4;
	ptsc_side_t side_s4;
	ptsc_side_t d2_fix;
	always_comb begin
		d2_fix = d2_side;
		if (d2_quo < DIV_STEPS'(2)) begin
			d2_fix.period = CNT_W'(2);
		end else if (d2_quo > DIV_STEPS'(COUNTER_RANGE)) begin
			d2_fix.period = CNT_W'(COUNTER_RANGE);
		end else begin
			d2_fix.period = CNT_W'(d2_quo);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= d2_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= d2_fix;
		end
	end

	// Stage 5: form period * duty
	logic                 vld_s5;
	ptsc_side_t           side_s5;
	logic [DIV_STEPS-1:0] pd_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			pd_s5   <= DIV_STEPS'(side_s4.period) * DIV_STEPS'(side_s4.duty);
		end
	end

	// Divider 3: pulse = round(period * duty / max_duty)
	logic [DIV_NUM_W-1:0] d3_num;
	logic [DIV_DEN_W-1:0] d3_den;
	logic                 d3_vld;
	logic [DIV_STEPS-1:0] d3_quo;
	ptsc_side_t           d3_side;
	assign d3_den = DIV_DEN_W'(max_duty_q);
	assign d3_num = DIV_NUM_W'(pd_s5) + DIV_NUM_W'(max_duty_q >> 1);

	ptsc_div u_div_pulse (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(vld_s5), .num(d3_num), .den(d3_den), .side_in(side_s5),
		.out_vld(d3_vld), .quo(d3_quo), .side_out(d3_side)
	);

	// Stage 6: keep the pulse, zero when the duty scale is zero
	logic       vld_s6;
	ptsc_side_t side_s6;
	ptsc_side_t d3_fix;
	always_comb begin
		d3_fix       = d3_side;
		d3_fix.pulse = (max_duty_q == 16'd0) ? '0 : CNT_W'(d3_quo);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= d3_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= d3_fix;
		end
	end

	// Stage 7: form prescaler * period
	logic                 vld_s7;
	ptsc_side_t           side_s7;
	logic [DIV_DEN_W-1:0] pp_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_s6;
			pp_s7   <= DIV_DEN_W'(side_s6.presc) * DIV_DEN_W'(side_s6.period);
		end
	end

	// Divider 4: actual = round(clock / (prescaler * period))
	logic [DIV_NUM_W-1:0] d4_num;
	logic                 d4_vld;
	logic [DIV_STEPS-1:0] d4_quo;
	ptsc_side_t           d4_side;
	assign d4_num = DIV_NUM_W'(clk_hz_q) + DIV_NUM_W'(pp_s7 >> 1);

	ptsc_div u_div_actual (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(vld_s7), .num(d4_num), .den(pp_s7), .side_in(side_s7),
		.out_vld(d4_vld), .quo(d4_quo), .side_out(d4_side)
	);

	// Output register: load values, or zeros for an invalid transaction
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= d4_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			if (d4_side.ok) begin
				result_code    <= RESULT_OK;
				prescaler_load <= 16'(d4_side.presc - CNT_W'(1));
				reload_load    <= 16'(d4_side.period - CNT_W'(1));
				compare_load   <= d4_side.pulse;
				achieved_freq  <= d4_quo[31:0];
				output_enabled <= d4_side.en;
			end else begin
				result_code    <= RESULT_INVALID;
				prescaler_load <= '0;
				reload_load    <= '0;
				compare_load   <= '0;
				achieved_freq  <= '0;
				output_enabled <= 1'b0;
			end
		end
	end
	assign out_valid = out_valid_q;

	`PTSC_ASSERT_IMP(a_invalid_zero, out_valid && result_code == RESULT_INVALID,
		prescaler_load == '0 && reload_load == '0 && compare_load == '0 && !output_enabled)
	`PTSC_ASSERT_IMP(a_period_min, out_valid && result_code == RESULT_OK, reload_load != '0)
	`PTSC_ASSERT_IMP(a_pulse_le_period, out_valid && result_code == RESULT_OK,
		compare_load <= 17'(reload_load) + 17'd1)

endmodule
